// ===== rtl/qmf16_pkg.sv =====
// ----------------------------------------------------------------------------
// QMF16 synthesis package
// Shared widths, register indexes and filter tap tables.
// ----------------------------------------------------------------------------
package qmf16_pkg;

  localparam int unsigned MAX_LINE_DEF    = 512;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IDX_W           = 9;
  localparam int unsigned LEN_W           = 10;
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned ADV_W           = 5;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned COEF_W          = 16;
  localparam int unsigned HALF_TAPS       = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LINE_LENGTH  = 3'd0,
    REG_LOW_SCALE    = 3'd1,
    REG_HIGH_SCALE   = 3'd2,
    REG_LOW_ADVANCE  = 3'd3,
    REG_HIGH_ADVANCE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  // Tap for band (0 low, 1 high), phase (0 odd output, 1 even output), step m.
  function automatic logic signed [COEF_W-1:0] tap_coef(input logic high,
                                                        input logic first,
                                                        input logic [2:0] m);
    logic [3:0] t;
    logic signed [COEF_W-1:0] c;
    t = {m, first};
    c = '0;
    if (!high) begin
      case (t)
        4'd0, 4'd15: c = 16'sd34;
        4'd1, 4'd14: c = -16'sd166;
        4'd2, 4'd13: c = -16'sd85;
        4'd3, 4'd12: c = 16'sd906;
        4'd4, 4'd11: c = -16'sd317;
        4'd5, 4'd10: c = -16'sd2962;
        4'd6, 4'd9:  c = 16'sd3205;
        default:     c = 16'sd15762;
      endcase
    end else begin
      case (t)
        4'd0:  c = -16'sd34;
        4'd1:  c = -16'sd166;
        4'd2:  c = 16'sd85;
        4'd3:  c = 16'sd906;
        4'd4:  c = 16'sd317;
        4'd5:  c = -16'sd2962;
        4'd6:  c = -16'sd3205;
        4'd7:  c = 16'sd15762;
        4'd8:  c = -16'sd15762;
        4'd9:  c = 16'sd3205;
        4'd10: c = 16'sd2962;
        4'd11: c = -16'sd317;
        4'd12: c = -16'sd906;
        4'd13: c = -16'sd85;
        4'd14: c = 16'sd166;
        default: c = 16'sd34;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== rtl/qmf16_if.sv =====
// ----------------------------------------------------------------------------
// QMF16 stream interfaces
// Valid/ready channels for command words and output pair words.
// ----------------------------------------------------------------------------
interface qmf16_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [8:0]                    sample_index;
  logic signed [SAMPLE_BITS-1:0] low_sample;
  logic signed [SAMPLE_BITS-1:0] high_sample;
  modport source (output valid, command, sample_index, low_sample, high_sample,
                  input ready);
  modport sink (input valid, command, sample_index, low_sample, high_sample,
                output ready);
endinterface

interface qmf16_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] even_out;
  logic signed [SAMPLE_BITS-1:0] odd_out;
  modport source (output valid, even_out, odd_out, input ready);
  modport sink (input valid, even_out, odd_out, output ready);
endinterface

// ===== rtl/qmf16_subband_synthesis_line.sv =====
// ----------------------------------------------------------------------------
// QMF16 subband synthesis line
// Two-band 16-tap QMF synthesis over one line held in two sample memories.
// ----------------------------------------------------------------------------
// A load word writes both band memories at its index when the index is below MAX_LINE.
// A compute word first reduces the band bases modulo 2N (ST_MOD), then makes the 16
// memory reads (ST_READ), scales the sums (ST_SCALE) and holds the result (ST_OUT).
// The next word is taken only after the result has been accepted; load words can
// follow back to back.
// Synchronous active-low reset clears control state and the registers to
// their defaults; the sample memories are not cleared.
module qmf16_subband_synthesis_line #(
  parameter int unsigned MAX_LINE    = qmf16_pkg::MAX_LINE_DEF,
  parameter int unsigned SAMPLE_BITS = qmf16_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qmf16_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [qmf16_pkg::CFG_DATA_W-1:0]    cfg_data,
  qmf16_in_if.sink                            in_word,
  qmf16_out_if.source                         out_word
);
  import qmf16_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_LINE);
  localparam int unsigned NW   = AW + 1;
  localparam int unsigned PW   = NW + 1;
  localparam int unsigned KW   = 10;
  localparam int unsigned BW   = $clog2(KW);
  localparam int unsigned ACCW = SAMPLE_BITS + COEF_W + 4;
  localparam int unsigned PRW  = ACCW + GAIN_W + 1;
  localparam int unsigned QW   = PRW - 29;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  logic signed [SAMPLE_BITS-1:0] low_mem [MAX_LINE];
  logic signed [SAMPLE_BITS-1:0] high_mem [MAX_LINE];

  state_t state_r, state_nxt;
  logic [LEN_W-1:0]  line_length_r;
  logic [GAIN_W-1:0] low_scale_r, high_scale_r;
  logic [ADV_W-1:0]  low_advance_r, high_advance_r;

  logic [4:0]  step_r;
  logic [8:0]  k_r;
  logic [NW-1:0] n_r;
  logic [PW-1:0] p_r;
  logic [BW-1:0] bit_r;
  logic [PW-1:0] lo_base_r, hi_base_r, lo_pos_r, hi_pos_r;

  logic signed [SAMPLE_BITS-1:0] low_rd_r, high_rd_r;
  logic        rd_vld_r, rd_mir_r, rd_first_r;
  logic [2:0]  rd_m_r;
  logic signed [ACCW-1:0] acc_lo_e_r, acc_hi_e_r, acc_lo_o_r, acc_hi_o_r;
  logic signed [SAMPLE_BITS-1:0] even_r, odd_r;
  logic signed [SAMPLE_BITS:0]   lo_val_r, hi_val_r;

  // The bases k + advance/2 are reduced modulo 2N one bit per cycle, then
  // each read position steps down by one with wrap, restarting at base + 1 for the odd phase.
  logic          s_first;
  logic [2:0]    s_m;
  logic [KW-1:0] lo_num, hi_num;
  logic [PW:0]   lo_sh, hi_sh;
  logic [PW-1:0] lo_base_nxt, hi_base_nxt;
  logic          s_mir, h_mir;
  logic [PW-1:0] s_fold, h_fold;
  logic [AW-1:0] s_addr, h_addr;

  always_comb begin
    s_first = ~step_r[3];
    s_m     = step_r[2:0];
    lo_num  = KW'(k_r) + KW'(low_advance_r[ADV_W-1:1]);
    hi_num  = KW'(k_r) + KW'(high_advance_r[ADV_W-1:1]);
    lo_sh   = {lo_base_r, lo_num[bit_r]};
    hi_sh   = {hi_base_r, hi_num[bit_r]};
    lo_base_nxt = (lo_sh >= (PW+1)'(p_r)) ? PW'(lo_sh - (PW+1)'(p_r)) : PW'(lo_sh);
    hi_base_nxt = (hi_sh >= (PW+1)'(p_r)) ? PW'(hi_sh - (PW+1)'(p_r)) : PW'(hi_sh);
    s_mir  = (lo_pos_r >= PW'(n_r));
    s_fold = s_mir ? (p_r - PW'(1) - lo_pos_r) : lo_pos_r;
    s_addr = s_fold[AW-1:0];
    h_mir  = (hi_pos_r >= PW'(n_r));
    h_fold = h_mir ? (p_r - PW'(1) - hi_pos_r) : hi_pos_r;
    h_addr = h_fold[AW-1:0];
  end

  logic in_acc, out_acc, load_we;
  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc  = in_word.valid & in_word.ready;
  assign load_we = in_acc && (in_word.command == CMD_LOAD) &&
                   (32'(in_word.sample_index) < MAX_LINE);
  assign out_acc = out_word.valid & out_word.ready;
  assign out_word.valid    = (state_r == ST_OUT);
  assign out_word.even_out = even_r;
  assign out_word.odd_out  = odd_r;

  always_ff @(posedge clk) begin
    if (load_we) begin
      low_mem[AW'(in_word.sample_index)]  <= in_word.low_sample;
      high_mem[AW'(in_word.sample_index)] <= in_word.high_sample;
    end
    low_rd_r  <= low_mem[s_addr];
    high_rd_r <= high_mem[h_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_word.command == CMD_COMPUTE) state_nxt = ST_MOD;
      ST_MOD:   if (bit_r == '0) state_nxt = ST_READ;
      ST_READ:  if (step_r == 5'd17) state_nxt = ST_SCALE;
      ST_SCALE: if (step_r == 5'd20) state_nxt = ST_OUT;
      ST_OUT:   if (out_acc) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic [NW-1:0] n_clamp;
  always_comb begin
    n_clamp = NW'(MAX_LINE);
    if (line_length_r == '0) n_clamp = NW'(1);
    else if (32'(line_length_r) < MAX_LINE) n_clamp = NW'(line_length_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      line_length_r  <= LEN_W'(512);
      low_scale_r    <= GAIN_W'(11585);
      high_scale_r   <= GAIN_W'(11585);
      low_advance_r  <= ADV_W'(14);
      high_advance_r <= ADV_W'(14);
      step_r         <= '0;
      rd_vld_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_LENGTH:  line_length_r  <= cfg_data[LEN_W-1:0];
          REG_LOW_SCALE:    low_scale_r    <= cfg_data[GAIN_W-1:0];
          REG_HIGH_SCALE:   high_scale_r   <= cfg_data[GAIN_W-1:0];
          REG_LOW_ADVANCE:  low_advance_r  <= cfg_data[ADV_W-1:0];
          REG_HIGH_ADVANCE: high_advance_r <= cfg_data[ADV_W-1:0];
          default: ;
        endcase
      end
      rd_vld_r <= (state_r == ST_READ) && (step_r < 5'd16);
      if (state_r == ST_IDLE || state_r == ST_MOD) step_r <= '0;
      else if (state_r != ST_OUT) step_r <= step_r + 5'd1;
    end
  end

  logic signed [SAMPLE_BITS:0]        lo_s, hi_s;
  logic signed [COEF_W-1:0]           lo_c, hi_c;
  logic signed [SAMPLE_BITS+COEF_W:0] lo_p, hi_p;

  always_comb begin
    lo_s = (SAMPLE_BITS+1)'(low_rd_r);
    hi_s = rd_mir_r ? -(SAMPLE_BITS+1)'(high_rd_r) : (SAMPLE_BITS+1)'(high_rd_r);
    lo_c = tap_coef(1'b0, rd_first_r, rd_m_r);
    hi_c = tap_coef(1'b1, rd_first_r, rd_m_r);
    lo_p = lo_s * lo_c;
    hi_p = hi_s * hi_c;
  end

  // Scaling: step 18 even phase, steps 19 and 20 odd phase.
  logic signed [ACCW-1:0] sc_lo_acc, sc_hi_acc;
  logic signed [PRW-1:0]  lo_prod, hi_prod;
  logic signed [SAMPLE_BITS:0] lo_q, hi_q;
  logic signed [SAMPLE_BITS+1:0] sum_v;
  logic signed [SAMPLE_BITS-1:0] sum_sat;

  function automatic logic signed [SAMPLE_BITS:0] round_sat(
      input logic signed [PRW-1:0] pr);
    logic signed [PRW-1:0] b;
    logic signed [QW-1:0]  q;
    logic signed [SAMPLE_BITS:0] r;
    b = pr + PRW'(1 << 28);
    q = b[PRW-1:29];
    if (q > QW'((1 << (SAMPLE_BITS-1)) - 1)) r = (SAMPLE_BITS+1)'((1 << (SAMPLE_BITS-1)) - 1);
    else if (q < -QW'(1 << (SAMPLE_BITS-1))) r = -(SAMPLE_BITS+1)'(1 << (SAMPLE_BITS-1));
    else r = q[SAMPLE_BITS:0];
    return r;
  endfunction

  always_comb begin
    sc_lo_acc = (step_r == 5'd18) ? acc_lo_e_r : acc_lo_o_r;
    sc_hi_acc = (step_r == 5'd18) ? acc_hi_e_r : acc_hi_o_r;
    lo_prod = PRW'(sc_lo_acc) * $signed({1'b0, low_scale_r});
    hi_prod = PRW'(sc_hi_acc) * $signed({1'b0, high_scale_r});
    lo_q = round_sat(lo_prod);
    hi_q = round_sat(hi_prod);
    sum_v = (SAMPLE_BITS+2)'(lo_val_r) + (SAMPLE_BITS+2)'(hi_val_r);
    if (sum_v > (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1))
      sum_sat = SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
    else if (sum_v < -(SAMPLE_BITS+2)'(1 << (SAMPLE_BITS-1)))
      sum_sat = SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
    else sum_sat = sum_v[SAMPLE_BITS-1:0];
  end

  logic sc_vld_r, sc_even_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      k_r <= in_word.sample_index;
      n_r <= n_clamp;
      p_r <= {n_clamp, 1'b0};
      bit_r <= BW'(KW - 1);
      lo_base_r <= '0;
      hi_base_r <= '0;
      acc_lo_e_r <= '0;
      acc_hi_e_r <= '0;
      acc_lo_o_r <= '0;
      acc_hi_o_r <= '0;
    end
    if (state_r == ST_MOD) begin
      bit_r     <= bit_r - BW'(1);
      lo_base_r <= lo_base_nxt;
      hi_base_r <= hi_base_nxt;
      lo_pos_r  <= lo_base_nxt;
      hi_pos_r  <= hi_base_nxt;
    end else if (state_r == ST_READ) begin
      if (step_r == 5'd7) begin
        lo_pos_r <= (lo_base_r == p_r - PW'(1)) ? '0 : lo_base_r + PW'(1);
        hi_pos_r <= (hi_base_r == p_r - PW'(1)) ? '0 : hi_base_r + PW'(1);
      end else begin
        lo_pos_r <= (lo_pos_r == '0) ? p_r - PW'(1) : lo_pos_r - PW'(1);
        hi_pos_r <= (hi_pos_r == '0) ? p_r - PW'(1) : hi_pos_r - PW'(1);
      end
    end
    rd_mir_r   <= h_mir;
    rd_first_r <= s_first;
    rd_m_r     <= s_m;
    if (rd_vld_r) begin
      if (rd_first_r) begin
        acc_lo_e_r <= acc_lo_e_r + ACCW'(lo_p);
        acc_hi_e_r <= acc_hi_e_r + ACCW'(hi_p);
      end else begin
        acc_lo_o_r <= acc_lo_o_r + ACCW'(lo_p);
        acc_hi_o_r <= acc_hi_o_r + ACCW'(hi_p);
      end
    end
    sc_vld_r  <= (state_r == ST_SCALE);
    sc_even_r <= (step_r == 5'd18);
    if (state_r == ST_SCALE) begin
      lo_val_r <= lo_q;
      hi_val_r <= hi_q;
    end
    if (sc_vld_r) begin
      if (sc_even_r) even_r <= sum_sat;
      else odd_r <= sum_sat;
    end
  end

endmodule

// ===== rtl/qmf16_checker.sv =====
// ----------------------------------------------------------------------------
// QMF16 port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module qmf16_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_even,
  input logic [15:0] out_odd
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_even) && $stable(out_odd))
    else $error("Output word changed while stalled.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Input accepted while a result is pending.");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !in_ready)
    else $error("Compute word did not occupy the block.");

  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command |=> !out_valid)
    else $error("Load word produced a result.");

endmodule

bind qmf16_subband_synthesis_line qmf16_checker u_qmf16_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .in_command (in_word.command),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_even   (out_word.even_out),
  .out_odd    (out_word.odd_out)
);

// ===== sim/tb_qmf16_subband_synthesis_line.sv =====
// ----------------------------------------------------------------------------
// QMF16 subband synthesis line testbench
// Loads band lines and requests output pairs over several register settings.
// A clocked driver sends queued words in bursts and the receiver stalls on a
// pattern of its own. A predictor of the filter bank checks each output pair.
// ----------------------------------------------------------------------------
module tb_qmf16_subband_synthesis_line;
  import qmf16_pkg::*;

  localparam int           WATCHDOG_LIMIT = 20000;
  localparam int           SETTLE_CYCLES  = 40;
  localparam logic [2:0]   REG_UNUSED     = 3'd7;

  typedef struct packed {
    cmd_t              command;
    logic [8:0]        sample_index;
    logic signed [15:0] low_sample;
    logic signed [15:0] high_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] even_out;
    logic signed [15:0] odd_out;
  } out_pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qmf16_in_if  #(.SAMPLE_BITS(16)) in_word ();
  qmf16_out_if #(.SAMPLE_BITS(16)) out_word ();

  qmf16_subband_synthesis_line u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_word(in_word.sink), .out_word(out_word.source)
  );

  int low_tap  [16] = '{34, -166, -85, 906, -317, -2962, 3205, 15762,
                        15762, 3205, -2962, -317, 906, -85, -166, 34};
  int high_tap [16] = '{-34, -166, 85, 906, 317, -2962, -3205, 15762,
                        -15762, 3205, 2962, -317, -906, -85, 166, 34};

  logic signed [15:0] low_line  [512];
  logic signed [15:0] high_line [512];
  int unsigned line_len_reg, low_gain, high_gain, low_adv, high_adv;

  in_word_t  pending_words [$];
  out_pair_t expected_pairs [$];
  int  errors = 0;
  int  pairs_checked = 0;
  int  words_sent = 0;
  int  stall_cycles = 0;
  bit  took = 0;
  int  burst_left = 4;
  int  gap_left = 0;
  bit  quiet_phase = 0;
  int  stall_left = 0;
  int  run_left = 3;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint band_acc(bit high, bit first, int base, int n);
    longint acc;
    longint s;
    int r;
    bit mir;
    acc = 0;
    for (int m = 0; m < 8; m++) begin
      r = (base - m) % (2 * n);
      if (r < 0) r += 2 * n;
      mir = (r >= n);
      if (mir) r = 2 * n - 1 - r;
      s = high ? longint'(high_line[r]) : longint'(low_line[r]);
      if (high && mir) s = -s;
      acc += longint'(high ? high_tap[2*m+first] : low_tap[2*m+first]) * s;
    end
    return acc;
  endfunction

  function automatic longint scale_band(longint acc, int unsigned gain);
    longint prod;
    prod = acc * longint'(gain);
    return sat16((prod + (longint'(1) << 28)) >>> 29);
  endfunction

  function automatic out_pair_t predict_pair(int k);
    out_pair_t p;
    int n, lb, hb;
    n = int'(line_len_reg);
    if (n < 1) n = 1;
    if (n > 512) n = 512;
    lb = k + int'(low_adv / 2);
    hb = k + int'(high_adv / 2);
    p.even_out = 16'(sat16(scale_band(band_acc(0, 1, lb, n), low_gain) +
                           scale_band(band_acc(1, 1, hb, n), high_gain)));
    p.odd_out  = 16'(sat16(scale_band(band_acc(0, 0, lb + 1, n), low_gain) +
                           scale_band(band_acc(1, 0, hb + 1, n), high_gain)));
    return p;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_load(int idx, logic [15:0] lo, logic [15:0] hi);
    in_word_t w;
    w.command = CMD_LOAD;
    w.sample_index = 9'(idx);
    w.low_sample = lo;
    w.high_sample = hi;
    pending_words.push_back(w);
  endtask

  task automatic queue_compute(int k);
    in_word_t w;
    w.command = CMD_COMPUTE;
    w.sample_index = 9'(k);
    w.low_sample = 16'($urandom);
    w.high_sample = 16'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_LENGTH:  line_len_reg = data & 16'h03ff;
      REG_LOW_SCALE:    low_gain = data;
      REG_HIGH_SCALE:   high_gain = data;
      REG_LOW_ADVANCE:  low_adv = data & 16'h001f;
      REG_HIGH_ADVANCE: high_adv = data & 16'h001f;
      default: ;
    endcase
  endtask

  task automatic configure(int n, int lg, int hg, int la, int ha);
    write_reg(REG_LINE_LENGTH, 16'(n));
    write_reg(REG_LOW_SCALE, 16'(lg));
    write_reg(REG_HIGH_SCALE, 16'(hg));
    write_reg(REG_LOW_ADVANCE, 16'(la));
    write_reg(REG_HIGH_ADVANCE, 16'(ha));
  endtask

  // Holds back until the block has gone quiet, then lets it settle.
  task automatic drain();
    while (pending_words.size() != 0 || in_word.valid || expected_pairs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int n, int extra);
    int top;
    quiet_phase = ($urandom_range(0, 3) == 0);
    top = (n > 512) ? 512 : n;
    if (n <= 512)
      for (int i = 0; i < n; i++) queue_load(i, rand_sample(), rand_sample());
    for (int i = 0; i < extra; i++) begin
      if ($urandom_range(0, 2) == 0)
        queue_load($urandom_range(0, 511), rand_sample(), rand_sample());
      else if ($urandom_range(0, 4) == 0)
        queue_compute($urandom_range(0, 511));
      else
        queue_compute($urandom_range(0, top - 1));
    end
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: presents queued words in bursts separated by random gaps (no gaps in a quiet phase).
  always @(negedge clk) begin
    if (rst_n && (!in_word.valid || took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_word.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_t w;
        w = pending_words.pop_front();
        in_word.valid <= 1'b1;
        in_word.command <= w.command;
        in_word.sample_index <= w.sample_index;
        in_word.low_sample <= w.low_sample;
        in_word.high_sample <= w.high_sample;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= quiet_phase ? 0 : $urandom_range(0, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_word.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: runs of ready separated by runs of stall; always ready in a quiet phase.
  always @(negedge clk) begin
    if (quiet_phase) begin
      out_word.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_word.ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_word.ready <= 1'b1;
    end else begin
      run_left <= $urandom_range(1, 6);
      stall_left <= $urandom_range(1, 30);
      out_word.ready <= 1'b0;
    end
  end

  // Monitor: models accepted words and checks output pairs.
  always @(posedge clk) begin
    took = rst_n && in_word.valid && in_word.ready;
    if (took) begin
      words_sent++;
      if (in_word.command == CMD_LOAD) begin
        low_line[in_word.sample_index] = in_word.low_sample;
        high_line[in_word.sample_index] = in_word.high_sample;
      end else begin
        expected_pairs.push_back(predict_pair(int'(in_word.sample_index)));
      end
    end
    if (rst_n && out_word.valid && out_word.ready) begin
      if (expected_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected pair even %0d odd %0d", $time,
                 out_word.even_out, out_word.odd_out);
      end else begin
        out_pair_t e;
        e = expected_pairs.pop_front();
        pairs_checked++;
        if (out_word.even_out !== e.even_out) begin
          errors++;
          $display("%0t: even_out expected %0d actual %0d", $time,
                   e.even_out, out_word.even_out);
        end
        if (out_word.odd_out !== e.odd_out) begin
          errors++;
          $display("%0t: odd_out expected %0d actual %0d", $time,
                   e.odd_out, out_word.odd_out);
        end
      end
    end
    if (took || (out_word.valid && out_word.ready) ||
        (pending_words.size() == 0 && !in_word.valid && expected_pairs.size() == 0))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_qmf16_subband_synthesis_line: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_word.valid = 1'b0;
    in_word.command = CMD_LOAD;
    in_word.sample_index = '0;
    in_word.low_sample = '0;
    in_word.high_sample = '0;
    out_word.ready = 1'b0;
    line_len_reg = 512;
    low_gain = 11585;
    high_gain = 11585;
    low_adv = 14;
    high_adv = 14;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Short line with extreme samples, edge pair indices and pairs past the line.
    configure(8, 65535, 65535, 31, 0);
    write_reg(REG_UNUSED, 16'hffff);
    queue_load(0, 16'h7fff, 16'h8000);
    queue_load(1, 16'h8000, 16'h7fff);
    queue_load(2, 16'h7fff, 16'h7fff);
    queue_load(3, 16'h8000, 16'h8000);
    queue_load(4, 16'h0000, 16'hffff);
    queue_load(5, 16'h5555, 16'haaaa);
    queue_load(6, 16'haaaa, 16'h5555);
    queue_load(7, 16'h0001, 16'hfffe);
    queue_load(9, 16'h1234, 16'h4321);
    queue_load(511, 16'h7fff, 16'h8000);
    queue_compute(0);
    queue_compute(1);
    queue_compute(7);
    queue_compute(8);
    queue_compute(15);
    queue_compute(511);
    drain();
    configure(8, 0, 0, 0, 31);
    queue_compute(0);
    queue_compute(3);
    queue_compute(511);
    drain();

    configure(16, 11585, 11585, 14, 14);
    random_phase(16, 60);
    configure(37, 16384, 40000, 7, 22);
    random_phase(37, 75);
    configure(100, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 31), $urandom_range(0, 31));
    random_phase(100, 75);
    configure(512, 65535, 0, 31, 31);
    random_phase(512, 50);
    configure(1023, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 31), $urandom_range(0, 31));
    random_phase(1023, 40);
    configure(8, 0, 65535, 0, 0);
    random_phase(8, 60);

    $display("Sent %0d words and checked %0d output pairs", words_sent, pairs_checked);
    $display("Line lengths 8 to 512 plus an over-range length, gains and advances at extremes");
    if (errors == 0) begin
      $display("tb_qmf16_subband_synthesis_line: done, clean");
    end else begin
      $display("tb_qmf16_subband_synthesis_line: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qmf16_pkg.sv
rtl/qmf16_if.sv
rtl/qmf16_subband_synthesis_line.sv
rtl/qmf16_checker.sv
sim/tb_qmf16_subband_synthesis_line.sv
